// File: src/lzw12_pkg.sv
package lzw12_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam logic [15:0] ROOT_PREV = 16'hFFFF;
    localparam logic [11:0] PROBE_STEP = 12'd101;
    localparam logic [11:0] CODES_INIT = 12'd3840;

    // one dictionary slot
    typedef struct packed {
        logic        used;
        logic        has_link;
        logic [11:0] link;
        logic [15:0] pred;
        logic [7:0]  follower;
    } entry_t;

    // one accepted input word passed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_INS_HASH,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_WALK,
        ST_INS_PROBE,
        ST_INS_LINK,
        ST_INS_WR,
        ST_LK_HASH,
        ST_LK_RD,
        ST_LK_CHK,
        ST_EMIT,
        ST_FINAL,
        ST_OUT
    } state_t;

endpackage

// File: src/lzw12_front.sv
module lzw12_front
    import lzw12_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // data_byte
    input  logic [1:0] s_axis_tuser,    // first, last
    input  logic       q_pop,
    output logic       q_valid,
    output item_t      q_item
);

    // two-entry queue between input side and engine
    item_t      mem_reg [2];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push = s_axis_tvalid && s_axis_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rptr_reg];

    // advance pointers
    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ (q_pop && q_valid);
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

    // store word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= '{data_byte: s_axis_tdata, first: s_axis_tuser[0],
                                   last: s_axis_tuser[1]};
        end
    end

endmodule

// File: src/lzw12_back.sv
module lzw12_back
    import lzw12_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic [1:0] m_axis_tuser
);

    localparam logic [12:0] LAST_SLOT = 13'(TABLE_ENTRIES - 1);
    localparam logic [12:0] STEP_LIMIT = 13'(TABLE_ENTRIES);

    // dictionary memory, one read and one write per cycle
    entry_t            dict_mem [TABLE_ENTRIES];
    entry_t            rd_reg;
    logic              wr_en;
    logic [11:0]       wr_addr;
    entry_t            wr_data;
    logic [11:0]       rd_addr;

    state_t            st_reg, st_next;
    state_t            ins_done_st;
    item_t             it_reg;
    logic              init_reg, init_next;
    logic              loading_reg, loading_next;
    logic              lk_root_reg, lk_root_next;
    logic [11:0]       slot_reg, slot_next;
    logic [11:0]       tail_reg, tail_next;
    entry_t            tail_ent_reg, tail_ent_next;
    logic [12:0]       cnt_reg, cnt_next;
    logic [15:0]       key_prev_reg, key_prev_next;
    logic [7:0]        key_byte_reg, key_byte_next;
    logic [16:0]       hkey;
    logic [17:0]       hsq;
    logic [11:0]       hash_reg;
    logic [7:0]        root_cnt_reg, root_cnt_next;
    logic [11:0]       prefix_reg, prefix_next;
    logic [11:0]       left_reg, left_next;
    logic [3:0]        half_reg, half_next;
    logic              hv_reg, hv_next;
    logic [7:0]        ob_reg [4];
    logic [7:0]        ob_next [4];
    logic [2:0]        on_reg, on_next;
    logic [2:0]        oi_reg, oi_next;
    logic              ol_reg, ol_next;
    logic              rd_match;
    logic              lk_end;
    logic              walk_more;
    logic              probe_fail;
    logic              ins_done;
    logic              run_end;

    assign rd_match = rd_reg.used && rd_reg.pred == key_prev_reg &&
                      rd_reg.follower == key_byte_reg;
    assign lk_end = !rd_reg.has_link || cnt_reg == LAST_SLOT;
    assign walk_more = rd_reg.has_link && cnt_reg != STEP_LIMIT;
    assign probe_fail = rd_reg.used && cnt_reg == STEP_LIMIT;
    assign ins_done = (st_reg == ST_INS_WR) || (st_reg == ST_INS_PROBE && probe_fail);
    assign run_end = (oi_reg == on_reg - 3'd1);

    // squaring hash: middle bits of the square of (prev + byte) | 0x800
    assign hkey = ({1'b0, key_prev_reg} + {9'd0, key_byte_reg}) | 17'h00800;
    assign hsq = 18'(hkey) * 18'(hkey);

    // memory port and registered hash
    always_ff @(posedge clk)
    begin
        if (wr_en)
            dict_mem[wr_addr] <= wr_data;
        rd_reg <= dict_mem[rd_addr];
        hash_reg <= hsq[17:6];
    end

    // next state
    always_comb
    begin
        ins_done_st = ST_LK_HASH;
        if (loading_reg && root_cnt_reg != 8'd255)
            ins_done_st = ST_INS_HASH;
        else if (loading_reg && init_reg)
            ins_done_st = ST_IDLE;
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:       if (q_valid) st_next = q_item.first ? ST_CLEAR : ST_LK_HASH;
            ST_CLEAR:      if (cnt_reg == LAST_SLOT) st_next = ST_INS_HASH;
            ST_INS_HASH:   st_next = ST_INS_RD;
            ST_INS_RD:     st_next = ST_INS_CHK;
            ST_INS_CHK:
                if (!rd_reg.used) st_next = ST_INS_WR;
                else if (rd_reg.has_link) st_next = ST_INS_WALK;
                else st_next = ST_INS_PROBE;
            ST_INS_WALK:   st_next = walk_more ? ST_INS_WALK : ST_INS_PROBE;
            ST_INS_PROBE:
                if (!rd_reg.used) st_next = ST_INS_LINK;
                else if (probe_fail) st_next = ins_done_st;
            ST_INS_LINK:   st_next = ST_INS_WR;
            ST_INS_WR:     st_next = ins_done_st;
            ST_LK_HASH:    st_next = ST_LK_RD;
            ST_LK_RD:      st_next = ST_LK_CHK;
            ST_LK_CHK:
                if (rd_match) st_next = ST_FINAL;
                else if (lk_end) st_next = lk_root_reg ? ST_FINAL : ST_EMIT;
            ST_EMIT:       st_next = (left_reg != 12'd0) ? ST_INS_HASH : ST_LK_HASH;
            ST_FINAL:      st_next = (on_reg != 3'd0 || it_reg.last) ? ST_OUT : ST_IDLE;
            ST_OUT:
                if (m_axis_tready && run_end) st_next = ST_IDLE;
            default:       st_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        init_next = init_reg;
        loading_next = loading_reg;
        lk_root_next = lk_root_reg;
        slot_next = slot_reg;
        tail_next = tail_reg;
        tail_ent_next = tail_ent_reg;
        cnt_next = cnt_reg;
        key_prev_next = key_prev_reg;
        key_byte_next = key_byte_reg;
        root_cnt_next = root_cnt_reg;
        prefix_next = prefix_reg;
        left_next = left_reg;
        half_next = half_reg;
        hv_next = hv_reg;
        ob_next = ob_reg;
        on_next = on_reg;
        oi_next = oi_reg;
        ol_next = ol_reg;
        wr_en = 1'b0;
        wr_addr = slot_reg;
        wr_data = '0;
        rd_addr = slot_reg;
        q_pop = 1'b0;
        case (st_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    on_next = 3'd0;
                    oi_next = 3'd0;
                    cnt_next = '0;
                    if (!q_item.first)
                    begin
                        key_prev_next = {4'd0, prefix_reg};
                        key_byte_next = q_item.data_byte;
                        lk_root_next = 1'b0;
                    end
                end
            ST_CLEAR:
            begin
                // zero one slot per cycle, then load the roots
                wr_en = 1'b1;
                wr_addr = cnt_reg[11:0];
                cnt_next = cnt_reg + 13'd1;
                loading_next = 1'b1;
                root_cnt_next = 8'd0;
                left_next = CODES_INIT;
                hv_next = 1'b0;
                half_next = 4'd0;
                key_prev_next = ROOT_PREV;
                key_byte_next = 8'd0;
            end
            ST_INS_RD, ST_LK_RD:
            begin
                slot_next = hash_reg;
                rd_addr = hash_reg;
                cnt_next = '0;
            end
            ST_INS_CHK:
                if (rd_reg.used)
                begin
                    if (rd_reg.has_link)
                    begin
                        tail_next = rd_reg.link;
                        rd_addr = rd_reg.link;
                        cnt_next = 13'd1;
                    end
                    else
                    begin
                        tail_next = slot_reg;
                        tail_ent_next = rd_reg;
                        slot_next = slot_reg + PROBE_STEP;
                        rd_addr = slot_reg + PROBE_STEP;
                        cnt_next = '0;
                    end
                end
            ST_INS_WALK:
                // follow the chain to its end, then start the probe past it
                if (walk_more)
                begin
                    tail_next = rd_reg.link;
                    rd_addr = rd_reg.link;
                    cnt_next = cnt_reg + 13'd1;
                end
                else
                begin
                    tail_ent_next = rd_reg;
                    slot_next = tail_reg + PROBE_STEP;
                    rd_addr = tail_reg + PROBE_STEP;
                    cnt_next = '0;
                end
            ST_INS_PROBE:
                if (rd_reg.used && !probe_fail)
                begin
                    slot_next = slot_reg + 12'd1;
                    rd_addr = slot_reg + 12'd1;
                    cnt_next = cnt_reg + 13'd1;
                end
            ST_INS_LINK:
            begin
                // link the chain end to the free slot
                wr_en = 1'b1;
                wr_addr = tail_reg;
                wr_data = tail_ent_reg;
                wr_data.has_link = 1'b1;
                wr_data.link = slot_reg;
            end
            ST_INS_WR:
            begin
                wr_en = 1'b1;
                wr_addr = slot_reg;
                wr_data = '{used: 1'b1, has_link: 1'b0, link: 12'd0,
                            pred: key_prev_reg, follower: key_byte_reg};
            end
            ST_LK_CHK:
                if (rd_match)
                    prefix_next = slot_reg;
                else if (lk_end)
                begin
                    if (lk_root_reg)
                        prefix_next = 12'd0;
                end
                else
                begin
                    slot_next = rd_reg.link;
                    rd_addr = rd_reg.link;
                    cnt_next = cnt_reg + 13'd1;
                end
            ST_EMIT:
            begin
                if (!hv_reg)
                begin
                    ob_next[on_reg[1:0]] = prefix_reg[11:4];
                    half_next = prefix_reg[3:0];
                    hv_next = 1'b1;
                    on_next = on_reg + 3'd1;
                end
                else
                begin
                    ob_next[on_reg[1:0]] = {half_reg, prefix_reg[11:8]};
                    ob_next[2'(on_reg + 3'd1)] = prefix_reg[7:0];
                    half_next = 4'd0;
                    hv_next = 1'b0;
                    on_next = on_reg + 3'd2;
                end
                if (left_reg != 12'd0)
                    left_next = left_reg - 12'd1;
                else
                begin
                    key_prev_next = ROOT_PREV;
                    lk_root_next = 1'b1;
                end
            end
            ST_FINAL:
            begin
                ol_next = it_reg.last;
                if (it_reg.last)
                begin
                    if (!hv_reg)
                    begin
                        ob_next[on_reg[1:0]] = prefix_reg[11:4];
                        ob_next[2'(on_reg + 3'd1)] = {prefix_reg[3:0], 4'd0};
                        on_next = on_reg + 3'd2;
                    end
                    else
                    begin
                        ob_next[on_reg[1:0]] = {half_reg, prefix_reg[11:8]};
                        ob_next[2'(on_reg + 3'd1)] = prefix_reg[7:0];
                        on_next = on_reg + 3'd2;
                    end
                    half_next = 4'd0;
                    hv_next = 1'b0;
                end
            end
            ST_OUT:
                if (m_axis_tready)
                    oi_next = oi_reg + 3'd1;
            default: ;
        endcase
        // after an insert: next root, or look up the byte as a root
        if (ins_done)
        begin
            if (loading_reg)
            begin
                root_cnt_next = root_cnt_reg + 8'd1;
                key_byte_next = root_cnt_reg + 8'd1;
                if (root_cnt_reg == 8'd255)
                begin
                    loading_next = 1'b0;
                    init_next = 1'b0;
                    key_byte_next = it_reg.data_byte;
                    lk_root_next = 1'b1;
                end
            end
            else
            begin
                key_prev_next = ROOT_PREV;
                lk_root_next = 1'b1;
            end
        end
    end

    // output bytes
    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_CLEAR;
            it_reg <= '0;
            init_reg <= 1'b1;
            loading_reg <= 1'b0;
            lk_root_reg <= 1'b0;
            slot_reg <= '0;
            tail_reg <= '0;
            tail_ent_reg <= '0;
            cnt_reg <= '0;
            key_prev_reg <= ROOT_PREV;
            key_byte_reg <= 8'd0;
            root_cnt_reg <= 8'd0;
            prefix_reg <= 12'd0;
            left_reg <= CODES_INIT;
            half_reg <= 4'd0;
            hv_reg <= 1'b0;
            on_reg <= 3'd0;
            oi_reg <= 3'd0;
            ol_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_IDLE && q_valid)
                it_reg <= q_item;
            init_reg <= init_next;
            loading_reg <= loading_next;
            lk_root_reg <= lk_root_next;
            slot_reg <= slot_next;
            tail_reg <= tail_next;
            tail_ent_reg <= tail_ent_next;
            cnt_reg <= cnt_next;
            key_prev_reg <= key_prev_next;
            key_byte_reg <= key_byte_next;
            root_cnt_reg <= root_cnt_next;
            prefix_reg <= prefix_next;
            left_reg <= left_next;
            half_reg <= half_next;
            hv_reg <= hv_next;
            on_reg <= on_next;
            oi_reg <= oi_next;
            ol_reg <= ol_next;
        end
    end

    assign m_axis_tvalid = (st_reg == ST_OUT);
    assign m_axis_tdata = ob_reg[oi_reg[1:0]];
    assign m_axis_tuser = {ol_reg && run_end, run_end};

endmodule

// File: src/lzw12_hashed_compressor_top.sv
// LZW 12-bit compressor, stream in / stream out.
// s_axis: one raw byte per word; tuser[0] = first (new buffer, reload the
// dictionary), tuser[1] = last (emit final code and flush the half byte).
// m_axis: packed code-stream bytes, tuser[0] = run_last (last byte caused
// by the input word), tuser[1] = buffer_end.
// A two-word queue takes input while the engine works; the engine handles
// one word at a time on a 4096 x 38 dictionary memory (one read, one write
// per cycle).
// A byte that extends the prefix runs the hash, read and check states, plus
// one check per chain step. A miss emits the code, inserts the new entry
// while codes are left and then looks the byte up as a root; an insert
// behind a used home slot adds the chain walk, probe steps and a link write.
// Result bytes then leave one per cycle while the receiver is ready. A first
// word clears all 4096 slots and inserts 256 roots; the queue fills and
// drops tready meanwhile. Reset starts the same clearing pass and root load.
// Results wait in a four-byte output buffer; a stalled receiver holds the
// engine, and the queue then fills and drops tready.
module lzw12_hashed_compressor_top
    import lzw12_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // data_byte
    input  logic [1:0] s_axis_tuser,    // first, last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // out_byte
    output logic [1:0] m_axis_tuser     // run_last, buffer_end
);

    logic  q_valid, q_pop;
    item_t q_item;

    lzw12_front u_front (
        .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .q_pop, .q_valid, .q_item
    );

    lzw12_back u_back (
        .clk, .rst_n, .q_valid, .q_item, .q_pop, .m_axis_tvalid,
        .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

`ifndef SYNTHESIS
    // stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    // buffer_end only on a run end
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("buffer_end without run_last");
`endif

endmodule
